/* sv/vcs_pkg.sv */
`timescale 1ns / 1ps

package vcs_pkg;

  localparam int ASCII_A = 65;
  localparam int ALPHA_N = 26;
  localparam int RECIP26 = 2521;
  localparam int SIZE_W  = 13;
  localparam int PHASE_W = 4;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CFG_KEY_FIRST  = 2'd0,
    CFG_KEY_SECOND = 2'd1,
    CFG_KEY_COUNT  = 2'd2,
    CFG_DECRYPT    = 2'd3
  } cfg_idx_t;

  // Truncating remainder by 26, magnitude up to 386.
  function automatic logic signed [5:0] mod26(input logic signed [10:0] x);
    logic [9:0]  mag;
    logic [21:0] prod;
    logic [4:0]  q;
    logic [9:0]  rem;
    mag  = x[10] ? 10'(-x) : 10'(x);
    prod = 22'(mag) * 22'(RECIP26);
    q    = prod[20:16];
    rem  = mag - 10'(q) * 10'(ALPHA_N);
    return x[10] ? -$signed({1'b0, rem[4:0]}) : $signed({1'b0, rem[4:0]});
  endfunction

  function automatic logic [7:0] cipher_enc(input logic [7:0] b, input logic [7:0] k);
    logic signed [10:0] s;
    logic signed [5:0]  r;
    s = 11'($signed(b)) + 11'($signed(k)) - 11'(2 * ASCII_A);
    r = mod26(s);
    return 8'(r) + 8'(ASCII_A);
  endfunction

  function automatic logic signed [5:0] cipher_dec(input logic [7:0] d,
                                                   input logic [7:0] k);
    logic signed [10:0] s;
    s = 11'($signed(d)) - 11'($signed(k)) + 11'(ALPHA_N);
    return mod26(s);
  endfunction

  function automatic logic [7:0] key_pick(input logic [63:0] lo_word,
                                          input logic [63:0] hi_word,
                                          input logic [PHASE_W-1:0] pos);
    logic [63:0] word;
    word = pos[3] ? hi_word : lo_word;
    return word[{pos[2:0], 3'b000} +: 8];
  endfunction

endpackage

/* sv/vcs_if.sv */
`timescale 1ns / 1ps

interface vcs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic        first;
  logic [11:0] addr;
  logic [7:0]  data_in;

  modport source (output valid, output op, output first, output addr, output data_in,
                  input ready);
  modport sink (input valid, input op, input first, input addr, input data_in,
                output ready);
endinterface

interface vcs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;
  logic       ok;

  modport source (output valid, output data_out, output ok, input ready);
  modport sink (input valid, input data_out, input ok, output ready);
endinterface

interface vcs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/vcs_ram.sv */
`timescale 1ns / 1ps

module vcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wr_data,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[addr];
    end
  end

endmodule

/* sv/vigenere_cipher_store.sv */
`timescale 1ns / 1ps
// Sequence: a write, clear or refused access is taken in S_IDLE; its result is registered
//   in S_EXEC; a served read issues the store's registered read in S_EXEC and registers
//   its result in S_LOOK. Throughput: one item at a time; a new item is taken only in
//   S_IDLE, and S_EXEC and S_LOOK wait while the result side stalls.
// Reset: synchronous; size, key phase, error latch, result valid, state, key and mode
//   registers reset; store contents are not cleared and need no clearing pass.
module vigenere_cipher_store #(
  parameter int STORE_DEPTH = 4096,
  parameter int KEY_MAX     = 16
) (
  input logic      clk,
  input logic      rst,
  vcs_cfg_if.sink  cfg,
  vcs_in_if.sink   item,
  vcs_out_if.source result
);
  import vcs_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_LOOK = 3'b100
  } state_t;

  state_t state;

  logic [63:0]        key_chars_first;
  logic [63:0]        key_chars_second;
  logic [4:0]         key_count;
  logic               decrypt_mode;

  logic [SIZE_W-1:0]  stored_size;
  logic [PHASE_W-1:0] key_phase;
  logic               bad_seen;

  logic [1:0]         cur_op;
  logic               cur_first;
  logic [11:0]        cur_addr;
  logic [7:0]         cur_data;
  logic [7:0]         cur_key;

  logic               result_valid;
  logic [7:0]         data_out;
  logic               ok;

  logic [4:0]         key_n;
  logic [PHASE_W-1:0] phase_base;
  logic [PHASE_W-1:0] phase_use;
  logic [PHASE_W-1:0] phase_adv;
  logic [7:0]         letter;
  logic               in_store;
  logic               in_size;
  logic [SIZE_W-1:0]  end_pos;
  logic               out_free;
  logic               mem_we;
  logic               mem_re;
  logic [7:0]         rd_data;
  logic signed [5:0]  dec_res;
  logic               bad;
  logic [7:0]         plain;

  assign cfg.ready       = !rst;
  assign item.ready      = !rst && (state == S_IDLE);
  assign result.valid    = result_valid;
  assign result.data_out = data_out;
  assign result.ok       = ok;

  assign out_free = !result_valid || result.ready;

  always_comb begin
    if (key_count == 5'd0) begin
      key_n = 5'd1;
    end else if (key_count > 5'(KEY_MAX)) begin
      key_n = 5'(KEY_MAX);
    end else begin
      key_n = key_count;
    end
  end

  assign phase_base = cur_first ? '0 : key_phase;
  assign phase_use  = ({1'b0, phase_base} >= key_n) ? '0 : phase_base;
  assign phase_adv  = ({1'b0, phase_use} + 5'd1 >= key_n) ? '0 : phase_use + PHASE_W'(1);
  assign letter     = key_pick(key_chars_first, key_chars_second, phase_use);
  assign in_store   = 32'(cur_addr) < 32'(STORE_DEPTH);
  assign in_size    = {1'b0, cur_addr} < stored_size;
  assign end_pos    = {1'b0, cur_addr} + 13'd1;

  assign mem_we = (state == S_EXEC) && out_free && (cur_op == OP_WRITE) && in_store;
  assign mem_re = (state == S_EXEC) && out_free && (cur_op == OP_READ) && in_store
                  && in_size;

  assign dec_res = cipher_dec(rd_data, cur_key);
  assign bad     = bad_seen || dec_res[5];
  assign plain   = bad ? 8'd0 : 8'(dec_res) + 8'(ASCII_A);

  vcs_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (mem_we),
    .re      (mem_re),
    .addr    (AW'(cur_addr)),
    .wr_data (cipher_enc(cur_data, letter)),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      key_chars_first  <= 64'(ASCII_A);
      key_chars_second <= '0;
      key_count        <= 5'd1;
      decrypt_mode     <= 1'b0;
      stored_size      <= '0;
      key_phase        <= '0;
      bad_seen         <= 1'b0;
      result_valid     <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          CFG_KEY_FIRST:  key_chars_first  <= cfg.data;
          CFG_KEY_SECOND: key_chars_second <= cfg.data;
          CFG_KEY_COUNT:  key_count        <= cfg.data[4:0];
          CFG_DECRYPT:    decrypt_mode     <= cfg.data[0];
          default:        key_count        <= key_count;
        endcase
      end

      if (result_valid && result.ready) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (item.valid) begin
            cur_op    <= item.op;
            cur_first <= item.first;
            cur_addr  <= item.addr;
            cur_data  <= item.data_in;
            state     <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            key_phase <= phase_base;
            bad_seen  <= cur_first ? 1'b0 : bad_seen;
            data_out  <= 8'd0;
            ok        <= 1'b0;
            state     <= S_IDLE;
            result_valid <= 1'b1;
            case (cur_op)
              OP_WRITE: begin
                if (in_store) begin
                  key_phase <= phase_adv;
                  ok        <= 1'b1;
                  if (stored_size < end_pos) begin
                    stored_size <= end_pos;
                  end
                end
              end
              OP_READ: begin
                if (in_store && in_size) begin
                  key_phase    <= phase_adv;
                  cur_key      <= letter;
                  result_valid <= 1'b0;
                  state        <= S_LOOK;
                end
              end
              OP_CLEAR: begin
                stored_size <= '0;
                ok          <= 1'b1;
              end
              default: ok <= 1'b0;
            endcase
          end
        end
        S_LOOK: begin
          if (out_free) begin
            bad_seen     <= bad;
            data_out     <= decrypt_mode ? plain : rd_data;
            ok           <= 1'b1;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/vcs_checker.sv */
`timescale 1ns / 1ps

module vcs_checker (
  input logic       clk,
  input logic       rst,
  input logic       item_valid,
  input logic       item_ready,
  input logic       result_valid,
  input logic       result_ready,
  input logic [7:0] data_out,
  input logic       ok
);

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(data_out) && $stable(ok))
    else $error("result beat changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("input taken again while an item is in work");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !ok |-> data_out == 8'd0)
    else $error("refused access returned nonzero data");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind vigenere_cipher_store vcs_checker u_vcs_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .data_out     (result.data_out),
  .ok           (result.ok)
);
